// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the report assembler modules.
// No dependencies; included by every file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TERA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define TERA_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define TERA_ASSERT(label, clk, rst_n, prop)
`define TERA_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/tera_pkg.sv =====
// Shared widths, event codes and controller/datapath interface types
// for the tablet event report assembler. No dependencies.
package tera_pkg;

    localparam int EV_W       = 16;
    localparam int VAL_W      = 32;
    localparam int POS_W      = 17;
    localparam int DY_W       = 32;
    localparam int BTN_W      = 3;
    localparam int PIX_W      = 16;
    localparam int PROD_W     = VAL_W + PIX_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = EV_W + VAL_W;
    localparam int S_TUSER_W  = EV_W;
    localparam int M_TDATA_W  = 88;
    localparam int M_TUSER_W  = 3;
    localparam int DIV_STEPS  = PIX_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Event types and codes.
    localparam logic [EV_W-1:0] EVT_SYN     = 16'h0000;
    localparam logic [EV_W-1:0] EVT_KEY     = 16'h0001;
    localparam logic [EV_W-1:0] EVT_REL     = 16'h0002;
    localparam logic [EV_W-1:0] EVT_ABS     = 16'h0003;
    localparam logic [EV_W-1:0] CODE_REPORT = 16'h0000;
    localparam logic [EV_W-1:0] CODE_ABS_X  = 16'h0000;
    localparam logic [EV_W-1:0] CODE_ABS_Y  = 16'h0001;
    localparam logic [EV_W-1:0] CODE_WHEEL  = 16'h0008;
    localparam logic [EV_W-1:0] CODE_LEFT   = 16'h0110;
    localparam logic [EV_W-1:0] CODE_RIGHT  = 16'h0111;
    localparam logic [EV_W-1:0] CODE_MIDDLE = 16'h0112;

    localparam logic [BTN_W-1:0] MASK_LEFT   = 3'b001;
    localparam logic [BTN_W-1:0] MASK_RIGHT  = 3'b010;
    localparam logic [BTN_W-1:0] MASK_MIDDLE = 3'b100;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK   = 3'd6;

    typedef struct packed {
        logic accept;
        logic load;
        logic mul;
        logic div_init;
        logic div_step;
        logic store;
        logic finish;
        logic emit_wheel;
        logic emit_motion;
        logic axis;
    } t_dp_cmd;

    typedef struct packed {
        logic sync_go;
        logic wheel_nz;
        logic motion;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/tera_dp.sv =====
// Datapath of the report assembler: configuration, event state, the shared
// multiply and restoring divide unit, and the output register. Uses tera_pkg.
`include "assert_macros.svh"
module tera_dp
    import tera_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [EV_W-1:0]             i_ev_type,
    input  logic [EV_W-1:0]             i_ev_code,
    input  logic signed [VAL_W-1:0]     i_ev_value,
    input  t_dp_cmd                     i_cmd,
    output t_dp_status                  o_status,
    input  logic                        i_m_tready,
    output logic                        o_m_tvalid,
    output logic signed [POS_W-1:0]     o_report_x,
    output logic signed [POS_W-1:0]     o_report_y,
    output logic signed [POS_W-1:0]     o_report_dx,
    output logic signed [DY_W-1:0]      o_report_dy,
    output logic [BTN_W-1:0]            o_report_buttons,
    output logic                        o_flag_wheel,
    output logic                        o_flag_absolute,
    output logic                        o_flag_relative,
    output logic                        o_last_report
);

    // Configuration.
    logic signed [VAL_W-1:0] r_x_min, r_x_max, r_y_min, r_y_max;
    logic [PIX_W-1:0]        r_width, r_height;
    logic                    r_locked;

    // Event state.
    logic signed [VAL_W-1:0] r_abs_x, r_abs_y;
    logic                    r_abs_seen, r_abs_pending, r_btn_pending;
    logic [VAL_W-1:0]        r_wheel_sum;
    logic [BTN_W-1:0]        r_btn_mask;
    logic [PIX_W-1:0]        r_sample_x, r_sample_y;
    logic [VAL_W-1:0]        r_wheel_snap;
    logic                    r_motion;

    // Scaling unit.
    logic [VAL_W-1:0]        r_v_off, r_den, r_rem;
    logic [PIX_W-1:0]        r_span_m1, r_quo, r_nx, r_ny;
    logic                    r_zero;
    logic [PROD_W-1:0]       r_prod;

    // Report fields and output register.
    logic signed [POS_W-1:0] r_px, r_py, r_dx;
    logic signed [DY_W-1:0]  r_dy;
    logic                    r_out_valid;
    logic signed [POS_W-1:0] r_o_x, r_o_y, r_o_dx;
    logic signed [DY_W-1:0]  r_o_dy;
    logic [BTN_W-1:0]        r_o_btn;
    logic                    r_o_wheel, r_o_abs, r_o_rel, r_o_last;

    logic [BTN_W-1:0]        w_btn_bit, w_btn_new;
    logic                    w_is_sync;
    logic [PIX_W-1:0]        w_gw, w_gh, w_span, w_q, w_qc, w_nx, w_ny;
    logic signed [VAL_W-1:0] w_v, w_lo, w_hi, w_vc;
    logic [VAL_W:0]          w_off, w_den, w_rem2, w_diff;
    logic                    w_ge;
    logic [POS_W-1:0]        w_dx, w_dy;

    always_comb begin
        case (i_ev_code)
            CODE_LEFT:   w_btn_bit = MASK_LEFT;
            CODE_RIGHT:  w_btn_bit = MASK_RIGHT;
            CODE_MIDDLE: w_btn_bit = MASK_MIDDLE;
            default:     w_btn_bit = '0;
        endcase
    end

    assign w_btn_new = (i_ev_value != '0) ? (r_btn_mask | w_btn_bit)
                                          : (r_btn_mask & ~w_btn_bit);
    assign w_is_sync = (i_ev_type == EVT_SYN) && (i_ev_code == CODE_REPORT);

    assign o_status.sync_go  = w_is_sync && (r_abs_seen || (r_wheel_sum != '0))
                               && ((r_wheel_sum != '0) || r_abs_pending || r_btn_pending);
    assign o_status.wheel_nz = (r_wheel_snap != '0);
    assign o_status.motion   = r_motion;
    assign o_status.out_free = !r_out_valid;

    // Axis setup: clamp the position into the device range.
    assign w_gw   = (r_width == '0) ? PIX_W'(1) : r_width;
    assign w_gh   = (r_height == '0) ? PIX_W'(1) : r_height;
    assign w_span = i_cmd.axis ? w_gh : w_gw;
    assign w_v    = i_cmd.axis ? r_abs_y : r_abs_x;
    assign w_lo   = i_cmd.axis ? r_y_min : r_x_min;
    assign w_hi   = i_cmd.axis ? r_y_max : r_x_max;
    assign w_vc   = (w_v < w_lo) ? w_lo : ((w_v > w_hi) ? w_hi : w_v);
    assign w_off  = {w_vc[VAL_W-1], w_vc} - {w_lo[VAL_W-1], w_lo};
    assign w_den  = {w_hi[VAL_W-1], w_hi} - {w_lo[VAL_W-1], w_lo};

    // One restoring division step per cycle.
    assign w_rem2 = {r_rem, r_quo[PIX_W-1]};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});
    assign w_diff = w_rem2 - {1'b0, r_den};

    assign w_q  = r_zero ? '0 : r_quo;
    assign w_qc = (w_q >= w_span) ? (w_span - PIX_W'(1)) : w_q;

    // Without any absolute position the pointer stays on the stored sample.
    assign w_nx = r_abs_seen ? r_nx : r_sample_x;
    assign w_ny = r_abs_seen ? r_ny : r_sample_y;
    assign w_dx = {1'b0, w_nx} - {1'b0, r_sample_x};
    assign w_dy = {1'b0, w_ny} - {1'b0, r_sample_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min       <= '0;
            r_x_max       <= VAL_W'(32767);
            r_y_min       <= '0;
            r_y_max       <= VAL_W'(32767);
            r_width       <= '0;
            r_height      <= '0;
            r_locked      <= 1'b0;
            r_abs_x       <= '0;
            r_abs_y       <= '0;
            r_abs_seen    <= 1'b0;
            r_abs_pending <= 1'b0;
            r_btn_pending <= 1'b0;
            r_wheel_sum   <= '0;
            r_btn_mask    <= '0;
            r_sample_x    <= '0;
            r_sample_y    <= '0;
            r_wheel_snap  <= '0;
            r_motion      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_X_MIN:  r_x_min  <= i_cfg_data;
                    CFG_X_MAX:  r_x_max  <= i_cfg_data;
                    CFG_Y_MIN:  r_y_min  <= i_cfg_data;
                    CFG_Y_MAX:  r_y_max  <= i_cfg_data;
                    CFG_WIDTH:  r_width  <= i_cfg_data[PIX_W-1:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[PIX_W-1:0];
                    CFG_LOCK:   r_locked <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                case (i_ev_type)
                    EVT_ABS: begin
                        if (i_ev_code == CODE_ABS_X) begin
                            r_abs_x       <= i_ev_value;
                            r_abs_seen    <= 1'b1;
                            r_abs_pending <= 1'b1;
                        end else if (i_ev_code == CODE_ABS_Y) begin
                            r_abs_y       <= i_ev_value;
                            r_abs_seen    <= 1'b1;
                            r_abs_pending <= 1'b1;
                        end
                    end
                    EVT_REL: begin
                        if (i_ev_code == CODE_WHEEL) begin
                            r_wheel_sum <= r_wheel_sum + $unsigned(i_ev_value);
                        end
                    end
                    EVT_KEY: begin
                        if (w_btn_bit != '0) begin
                            r_btn_mask <= w_btn_new;
                            if (w_btn_new != r_btn_mask) begin
                                r_btn_pending <= 1'b1;
                            end
                        end
                    end
                    EVT_SYN: begin
                        if (i_ev_code == CODE_REPORT) begin
                            r_wheel_snap  <= r_wheel_sum;
                            r_motion      <= r_abs_pending || r_btn_pending;
                            r_wheel_sum   <= '0;
                            r_abs_pending <= 1'b0;
                            r_btn_pending <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_sample_x <= w_nx;
                r_sample_y <= w_ny;
            end
            if (i_cmd.emit_wheel || i_cmd.emit_motion) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v_off   <= w_off[VAL_W-1:0];
            r_den     <= w_den[VAL_W-1:0];
            r_span_m1 <= w_span - PIX_W'(1);
            r_zero    <= (w_span <= PIX_W'(1)) || !(w_hi > w_lo);
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_v_off) * PROD_W'(r_span_m1);
        end
        if (i_cmd.div_init) begin
            r_rem <= r_prod[PROD_W-1:PIX_W];
            r_quo <= r_prod[PIX_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[VAL_W-1:0] : w_rem2[VAL_W-1:0];
            r_quo <= {r_quo[PIX_W-2:0], w_ge};
        end
        if (i_cmd.store) begin
            if (i_cmd.axis) begin
                r_ny <= w_qc;
            end else begin
                r_nx <= w_qc;
            end
        end
        if (i_cmd.finish) begin
            r_px <= r_locked ? '1 : $signed({1'b0, w_nx});
            r_py <= r_locked ? '1 : $signed({1'b0, w_ny});
            r_dx <= $signed(w_dx);
            r_dy <= DY_W'($signed(w_dy));
        end
        if (i_cmd.emit_wheel) begin
            r_o_x     <= r_px;
            r_o_y     <= r_py;
            r_o_dx    <= '0;
            r_o_dy    <= $signed(r_wheel_snap);
            r_o_btn   <= r_btn_mask;
            r_o_wheel <= 1'b1;
            r_o_abs   <= !r_locked;
            r_o_rel   <= 1'b0;
            r_o_last  <= !r_motion;
        end else if (i_cmd.emit_motion) begin
            r_o_x     <= r_px;
            r_o_y     <= r_py;
            r_o_dx    <= r_dx;
            r_o_dy    <= r_dy;
            r_o_btn   <= r_btn_mask;
            r_o_wheel <= 1'b0;
            r_o_abs   <= !r_locked;
            r_o_rel   <= r_locked;
            r_o_last  <= 1'b1;
        end
    end

    assign o_m_tvalid       = r_out_valid;
    assign o_report_x       = r_o_x;
    assign o_report_y       = r_o_y;
    assign o_report_dx      = r_o_dx;
    assign o_report_dy      = r_o_dy;
    assign o_report_buttons = r_o_btn;
    assign o_flag_wheel     = r_o_wheel;
    assign o_flag_absolute  = r_o_abs;
    assign o_flag_relative  = r_o_rel;
    assign o_last_report    = r_o_last;

    `TERA_ASSERT_NEVER(a_emit_over_busy, i_clk, i_rst_n, (i_cmd.emit_wheel || i_cmd.emit_motion) && r_out_valid)
    `TERA_ASSERT(a_rem_below_den, i_clk, i_rst_n, ((i_cmd.div_init || i_cmd.div_step) && !r_zero) |=> (r_rem < r_den))
    `TERA_ASSERT(a_x_on_screen, i_clk, i_rst_n, (i_cmd.store && !i_cmd.axis) |=> (r_nx < w_gw))

endmodule

// ===== rtl/tera_ctrl.sv =====
// Controller state machine of the report assembler: sequences the two axis
// scalings and the report emission. Uses tera_pkg.
`include "assert_macros.svh"
module tera_ctrl
    import tera_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_LOAD   = 9'b000000010,
        ST_MUL    = 9'b000000100,
        ST_DINIT  = 9'b000001000,
        ST_DIV    = 9'b000010000,
        ST_STORE  = 9'b000100000,
        ST_FINISH = 9'b001000000,
        ST_EMIT_W = 9'b010000000,
        ST_EMIT_M = 9'b100000000
    } t_state;

    t_state               r_state, n_state;
    logic                 r_axis, n_axis;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_cmd.axis = r_axis;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.sync_go) begin
                        n_state = ST_LOAD;
                        n_axis  = 1'b0;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DINIT;
            end
            ST_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                o_cmd.store = 1'b1;
                if (!r_axis) begin
                    n_axis  = 1'b1;
                    n_state = ST_LOAD;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = i_status.wheel_nz ? ST_EMIT_W : ST_EMIT_M;
            end
            ST_EMIT_W: begin
                if (i_status.out_free) begin
                    o_cmd.emit_wheel = 1'b1;
                    n_state          = i_status.motion ? ST_EMIT_M : ST_IDLE;
                end
            end
            ST_EMIT_M: begin
                if (i_status.out_free) begin
                    o_cmd.emit_motion = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_cnt   <= n_cnt;
        end
    end

    `TERA_ASSERT(a_sync_starts_x, i_clk, i_rst_n, (o_cmd.accept && i_status.sync_go) |=> (r_state == ST_LOAD && !r_axis))
    `TERA_ASSERT(a_full_divide, i_clk, i_rst_n, (r_state == ST_STORE) |-> ($past(r_state) == ST_DIV && $past(r_cnt) == DIV_CNT_W'(DIV_STEPS - 1)))
    `TERA_ASSERT(a_motion_needed, i_clk, i_rst_n, o_cmd.emit_motion |-> i_status.motion)

endmodule

// ===== rtl/tablet_event_report_assembler.sv =====
// Top level of the tablet event report assembler: stream ports, the
// configuration write channel and field packing. Uses tera_pkg, tera_ctrl, tera_dp.
//
// A key, wheel or axis word is absorbed in the cycle it is accepted, so such words
// stream at one per cycle while no report is being assembled. A sync word that
// produces reports starts two axis scalings, each one multiply plus a 16-step
// restoring divide. Such a sync holds the input through both scalings and the
// report emission (a wheel report first when the wheel sum is nonzero), and for as
// long as the downstream side stalls; the shared divider takes most of this time.
// Reset (i_rst_n low at a clock edge) clears all event state, restores default configuration.
module tablet_event_report_assembler
    import tera_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Event input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [15:0] ev_code, [47:16] ev_value
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    // [15:0] ev_type
    input  logic [S_TUSER_W-1:0]   s_axis_tuser,
    // Report output stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [16:0] report_x, [33:17] report_y, [50:34] report_dx, [82:51] report_dy,
    // [85:83] report_buttons, [87:86] zero
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    // [0] flag_wheel, [1] flag_absolute, [2] flag_relative
    output logic [M_TUSER_W-1:0]   m_axis_tuser,
    // last_report
    output logic                   m_axis_tlast,
    // Configuration write channel.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_dp_cmd                 w_cmd;
    t_dp_status              w_status;
    logic signed [POS_W-1:0] w_x, w_y, w_dx;
    logic signed [DY_W-1:0]  w_dy;
    logic [BTN_W-1:0]        w_btn;
    logic                    w_wheel, w_abs, w_rel;

    // Configuration registers take a write in any cycle; the host must write them
    // only while the block is idle, as the block itself does not enforce this.
    assign o_cfg_ready = 1'b1;

    // The controller accepts events only while idle, so event state is never
    // touched in the middle of a scaling run.
    tera_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath owns the output register, so new events are taken while a
    // finished report still waits for the downstream side.
    tera_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_ev_type        (s_axis_tuser),
        .i_ev_code        (s_axis_tdata[EV_W-1:0]),
        .i_ev_value       (s_axis_tdata[S_TDATA_W-1:EV_W]),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_m_tready       (m_axis_tready),
        .o_m_tvalid       (m_axis_tvalid),
        .o_report_x       (w_x),
        .o_report_y       (w_y),
        .o_report_dx      (w_dx),
        .o_report_dy      (w_dy),
        .o_report_buttons (w_btn),
        .o_flag_wheel     (w_wheel),
        .o_flag_absolute  (w_abs),
        .o_flag_relative  (w_rel),
        .o_last_report    (m_axis_tlast)
    );

    // Fields are packed from the lowest bit up and padded to whole bytes.
    assign m_axis_tdata = {2'b00, w_btn, w_dy, w_dx, w_y, w_x};
    assign m_axis_tuser = {w_rel, w_abs, w_wheel};

endmodule
